>>> hw/rtl/ppia_pkg.sv
// Shared types and constants for the polygon point-inside and area unit.
`timescale 1ns / 1ps
`default_nettype none

package ppia_pkg;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int COORD_WIDTH_DEF  = 16;

   localparam int REQ_TYPE_W = 2;
   localparam int AREA_W     = 38;
   localparam int VCOUNT_W   = 5;
   localparam int RSP_USED_W = 1 + AREA_W + VCOUNT_W + 1;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_QUERY  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_WALK,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic prime;
      logic issue;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic last_issue;
      logic pipe_busy;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/ppia_ctrl.sv
// Controller state machine for the polygon point-inside and area unit.
`timescale 1ns / 1ps
`default_nettype none

module ppia_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [ppia_pkg::REQ_TYPE_W-1:0] req_tuser,
   output ppia_pkg::dp_cmd_type                 cmd,
   input  wire ppia_pkg::dp_status_type         status
);

   ppia_pkg::state_type state_ff;
   ppia_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppia_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ppia_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tuser == ppia_pkg::REQ_QUERY && !status.count_zero) begin
                  state_in = ppia_pkg::ST_PRIME;
               end else begin
                  state_in = ppia_pkg::ST_COMMIT;
               end
            end
         end
         ppia_pkg::ST_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = ppia_pkg::ST_WALK;
         end
         ppia_pkg::ST_WALK: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ppia_pkg::ST_DRAIN;
            end
         end
         ppia_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ppia_pkg::ST_COMMIT;
            end
         end
         ppia_pkg::ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ppia_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppia_pkg::ST_IDLE;
         end
      endcase
   end

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit while result slot occupied");

   a_prime_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.prime |-> !status.count_zero)
      else $error("edge walk started on empty table");

endmodule

`default_nettype wire

>>> hw/rtl/ppia_datapath.sv
// Vertex table, edge pipeline, accumulators and result register.
`timescale 1ns / 1ps
`default_nettype none

module ppia_datapath #(
   parameter int MAX_VERTICES = ppia_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = ppia_pkg::COORD_WIDTH_DEF,
   localparam int REQ_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [REQ_DATA_W-1:0]           req_tdata,
   input  wire logic [ppia_pkg::REQ_TYPE_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [ppia_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire ppia_pkg::dp_cmd_type            cmd,
   output ppia_pkg::dp_status_type              status
);

   localparam int CW     = COORD_WIDTH;
   localparam int DW     = CW + 1;
   localparam int PW     = 2 * DW;
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int ACC_W  = PW + $clog2(MAX_VERTICES);
   localparam int ABS_W  = (ACC_W > ppia_pkg::AREA_W) ? ACC_W : ppia_pkg::AREA_W + 1;

   logic [ppia_pkg::REQ_TYPE_W-1:0] req_type_ff;
   logic signed [CW-1:0]            px_ff;
   logic signed [CW-1:0]            py_ff;
   logic [CNT_W-1:0]                count_ff;
   logic [CNT_W-1:0]                count_in;
   logic [ADDR_W-1:0]               idx_ff;
   logic [ADDR_W-1:0]               last_addr;
   logic [ADDR_W-1:0]               rd_addr;

   logic signed [CW-1:0] mem_x [MAX_VERTICES];
   logic signed [CW-1:0] mem_y [MAX_VERTICES];
   logic signed [CW-1:0] rd_x_ff;
   logic signed [CW-1:0] rd_y_ff;
   logic                 rd_valid_ff;
   logic                 rd_first_ff;

   logic signed [CW-1:0] prev_x_ff;
   logic signed [CW-1:0] prev_y_ff;
   logic signed [DW-1:0] dxp;
   logic signed [DW-1:0] dy;
   logic signed [DW-1:0] ex;
   logic signed [DW-1:0] ey;
   logic signed [DW-1:0] sx;
   logic signed [PW-1:0] lhs_ff;
   logic signed [PW-1:0] rhs_ff;
   logic signed [PW-1:0] term_ff;
   logic                 cand_ff;
   logic                 dpos_ff;
   logic                 s2_valid_ff;

   logic                 hit;
   logic                 cross_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0]     acc_mag;
   logic [ABS_W-1:0]     acc_ext;
   logic [ppia_pkg::AREA_W-1:0] area_sat;

   logic                 is_query;
   logic                 is_append;
   logic                 is_clear;
   logic                 table_full;
   logic                 rsp_valid_ff;
   logic [ppia_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign is_query   = req_type_ff == ppia_pkg::REQ_QUERY;
   assign is_append  = req_type_ff == ppia_pkg::REQ_APPEND;
   assign is_clear   = req_type_ff == ppia_pkg::REQ_CLEAR;
   assign table_full = count_ff == CNT_W'(MAX_VERTICES);
   assign last_addr  = ADDR_W'(count_ff - CNT_W'(1));
   assign rd_addr    = cmd.prime ? last_addr : idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff <= req_tuser;
         px_ff       <= $signed(req_tdata[CW-1:0]);
         py_ff       <= $signed(req_tdata[2*CW-1:CW]);
      end
      if (cmd.prime) begin
         idx_ff <= '0;
      end else if (cmd.issue) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit) begin
         if (is_clear) begin
            count_in = '0;
         end else if (is_append && !table_full) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && is_append && !table_full) begin
         mem_x[count_ff[ADDR_W-1:0]] <= px_ff;
         mem_y[count_ff[ADDR_W-1:0]] <= py_ff;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.prime | cmd.issue;
         s2_valid_ff <= rd_valid_ff & ~rd_first_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_ff <= cmd.prime;
   end

   // Edge (j, i): j is the previous vertex, i the one just read.
   assign dxp = $signed({px_ff[CW-1], px_ff}) - $signed({rd_x_ff[CW-1], rd_x_ff});
   assign dy  = $signed({prev_y_ff[CW-1], prev_y_ff}) - $signed({rd_y_ff[CW-1], rd_y_ff});
   assign ex  = $signed({prev_x_ff[CW-1], prev_x_ff}) - $signed({rd_x_ff[CW-1], rd_x_ff});
   assign ey  = $signed({py_ff[CW-1], py_ff}) - $signed({rd_y_ff[CW-1], rd_y_ff});
   assign sx  = $signed({prev_x_ff[CW-1], prev_x_ff}) + $signed({rd_x_ff[CW-1], rd_x_ff});

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end
      lhs_ff  <= dxp * dy;
      rhs_ff  <= ex * ey;
      term_ff <= sx * dy;
      cand_ff <= (rd_y_ff > py_ff) != (prev_y_ff > py_ff);
      dpos_ff <= prev_y_ff > rd_y_ff;
   end

   assign hit = cand_ff & (dpos_ff ? (lhs_ff < rhs_ff) : (rhs_ff < lhs_ff));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff   <= '0;
         cross_ff <= 1'b0;
      end else if (s2_valid_ff) begin
         acc_ff   <= acc_ff + {{(ACC_W - PW){term_ff[PW-1]}}, term_ff};
         cross_ff <= cross_ff ^ hit;
      end
   end

   assign acc_mag  = acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;
   assign acc_ext  = ABS_W'(acc_mag);
   assign area_sat = (|acc_ext[ABS_W-1:ppia_pkg::AREA_W]) ? '1
                                                           : acc_ext[ppia_pkg::AREA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {{ppia_pkg::RSP_PAD_W{1'b0}},
                         is_append & table_full,
                         ppia_pkg::VCOUNT_W'(count_in),
                         is_query ? area_sat : {ppia_pkg::AREA_W{1'b0}},
                         is_query & cross_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.count_zero = count_ff == '0;
   assign status.last_issue = idx_ff == last_addr;
   assign status.pipe_busy  = rd_valid_ff | s2_valid_ff;
   assign status.out_free   = ~rsp_valid_ff | rsp_tready;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond table depth");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (CNT_W'(idx_ff) < count_ff))
      else $error("edge read beyond stored vertices");

   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not present a result");

endmodule

`default_nettype wire

>>> hw/rtl/polygon_point_inside_and_area_unit.sv
// Top level of the polygon point-inside and area unit.
`timescale 1ns / 1ps
`default_nettype none

// Holds up to MAX_VERTICES polygon vertices and answers one result per request.
// Clear, append and unused codes go from the transfer to the commit state and
// then the result register. A query on n stored vertices steps the single read
// port of the vertex table once per edge (one priming read of the closing
// vertex, then n reads), followed by a multiply stage, a compare and accumulate
// stage, and the final absolute value and saturation into the result register.
// A query on an empty table skips the edge walk like a clear. A new request
// transfer is taken while an earlier result still waits on the response side;
// it stalls at completion only if that result has not been taken by then.
module polygon_point_inside_and_area_unit #(
   parameter int MAX_VERTICES = ppia_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = ppia_pkg::COORD_WIDTH_DEF,
   localparam int REQ_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // coord_x, coord_y, zero pad
   input  wire logic [REQ_DATA_W-1:0]           req_tdata,
   // req_type
   input  wire logic [ppia_pkg::REQ_TYPE_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // inside_res, area_doubled, vertex_count, status, zero pad
   output logic [ppia_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   ppia_pkg::dp_cmd_type    cmd;
   ppia_pkg::dp_status_type status;

   ppia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   ppia_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

`default_nettype wire

>>> tb/sv/polygon_answer_checker.sv
// Checker for the polygon unit: tracks the vertex table, predicts each answer and compares.
`timescale 1ns / 1ps
`default_nettype none

module polygon_answer_checker #(
   parameter int REQ_W = ((2 * ppia_pkg::COORD_WIDTH_DEF + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [REQ_W-1:0]                req_tdata,
   input  wire logic [ppia_pkg::REQ_TYPE_W-1:0] req_tuser,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [ppia_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                                   mismatches,
   output int                                   pending
);

   localparam longint AREA_SAT = (64'd1 << ppia_pkg::AREA_W) - 1;

   typedef struct packed {
      logic                          in_poly;
      logic [ppia_pkg::AREA_W-1:0]   area;
      logic [ppia_pkg::VCOUNT_W-1:0] vcount;
      logic                          status;
   } answer_type;

   logic signed [ppia_pkg::COORD_WIDTH_DEF-1:0] poly_x [ppia_pkg::MAX_VERTICES_DEF];
   logic signed [ppia_pkg::COORD_WIDTH_DEF-1:0] poly_y [ppia_pkg::MAX_VERTICES_DEF];
   int         held;
   int         answers_seen;
   answer_type answers_due [$];

   task automatic report_mismatch(input string what, input longint got_v,
                                  input longint want_v);
      $display("mismatch on answer %0d, %s: got %0d, expected %0d",
               answers_seen, what, got_v, want_v);
      mismatches++;
   endtask

   // Advance the vertex table by one request and return the answer it causes.
   function automatic answer_type polygon_answer(
      input logic [ppia_pkg::REQ_TYPE_W-1:0]             kind,
      input logic signed [ppia_pkg::COORD_WIDTH_DEF-1:0] px_in,
      input logic signed [ppia_pkg::COORD_WIDTH_DEF-1:0] py_in);
      answer_type ans;
      longint     px, py, xi, yi, xj, yj, d, lhs, rhs, acc;
      int         j, crossings;
      logic       hit;
      ans = '0;
      px = px_in;
      py = py_in;
      case (kind)
         ppia_pkg::REQ_CLEAR: begin
            held = 0;
         end
         ppia_pkg::REQ_APPEND: begin
            if (held < ppia_pkg::MAX_VERTICES_DEF) begin
               poly_x[held] = px_in;
               poly_y[held] = py_in;
               held++;
            end else begin
               ans.status = 1'b1;
            end
         end
         ppia_pkg::REQ_QUERY: begin
            acc = 0;
            crossings = 0;
            for (int i = 0; i < held; i++) begin
               j = (i == 0) ? held - 1 : i - 1;
               xi = poly_x[i];
               yi = poly_y[i];
               xj = poly_x[j];
               yj = poly_y[j];
               if ((yi > py) != (yj > py)) begin
                  d = yj - yi;
                  lhs = (px - xi) * d;
                  rhs = (xj - xi) * (py - yi);
                  hit = (d > 0) ? (lhs < rhs) : (rhs < lhs);
                  if (hit) crossings++;
               end
               acc += (xj + xi) * (yj - yi);
            end
            if (acc < 0) acc = -acc;
            if (acc > AREA_SAT) acc = AREA_SAT;
            ans.in_poly = crossings[0];
            ans.area = acc[ppia_pkg::AREA_W-1:0];
         end
         default: begin
         end
      endcase
      ans.vcount = held[ppia_pkg::VCOUNT_W-1:0];
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         held = 0;
         mismatches = 0;
         answers_seen = 0;
         answers_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.in_poly = rsp_tdata[0];
            got.area    = rsp_tdata[ppia_pkg::AREA_W:1];
            got.vcount  = rsp_tdata[ppia_pkg::AREA_W+ppia_pkg::VCOUNT_W:ppia_pkg::AREA_W+1];
            got.status  = rsp_tdata[ppia_pkg::AREA_W+ppia_pkg::VCOUNT_W+1];
            if (answers_due.size() == 0) begin
               report_mismatch("result with no request waiting", 0, 0);
            end else begin
               want = answers_due.pop_front();
               if (got.in_poly !== want.in_poly)
                  report_mismatch("inside_res", got.in_poly, want.in_poly);
               if (got.area !== want.area)
                  report_mismatch("area_doubled", got.area, want.area);
               if (got.vcount !== want.vcount)
                  report_mismatch("vertex_count", got.vcount, want.vcount);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
            end
            answers_seen++;
         end
         if (req_tvalid && req_tready)
            answers_due.insert(answers_due.size(),
               polygon_answer(req_tuser,
                              req_tdata[ppia_pkg::COORD_WIDTH_DEF-1:0],
                              req_tdata[2*ppia_pkg::COORD_WIDTH_DEF-1:ppia_pkg::COORD_WIDTH_DEF]));
      end
      pending <= answers_due.size();
   end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench top for the polygon unit: clock, reset, request stimulus, response pacing, verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb;

   localparam int REQ_W = ((2 * ppia_pkg::COORD_WIDTH_DEF + 7) / 8) * 8;
   localparam logic [ppia_pkg::REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1500;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [REQ_W-1:0]                req_tdata;
   logic [ppia_pkg::REQ_TYPE_W-1:0] req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [ppia_pkg::RSP_DATA_W-1:0] rsp_tdata;
   int                              mismatches;
   int                              pending;
   int                              items_sent;
   int                              cycles = 0;
   logic                            idle_on;
   logic                            hold_go;
   logic                            hold_rsp;

   polygon_point_inside_and_area_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   polygon_answer_checker #(.REQ_W(REQ_W)) chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Offer one request and hold it until the transfer.
   task automatic push_req(input logic [ppia_pkg::REQ_TYPE_W-1:0] kind,
                           input logic signed [ppia_pkg::COORD_WIDTH_DEF-1:0] x,
                           input logic signed [ppia_pkg::COORD_WIDTH_DEF-1:0] y);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
      if (kind != REQ_UNUSED) items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic signed [ppia_pkg::COORD_WIDTH_DEF-1:0] pick_coord(input bit wide);
      int r;
      r = $urandom_range(0, 15);
      if (wide) begin
         if (r == 0) return 16'sh8000;
         if (r == 1) return 16'sh7FFF;
         return ppia_pkg::COORD_WIDTH_DEF'($urandom);
      end
      return ppia_pkg::COORD_WIDTH_DEF'($urandom_range(0, 2000) - 1000);
   endfunction

   // Response side: random stalls, plus the long hold-off when requested.
   initial begin
      int stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      hold_rsp = 1'b0;
      wait (hold_go);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      bit wide_poly, held_off, drained;
      int k, q, n;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      idle_on    = 1'b1;
      hold_go    = 1'b0;
      items_sent = 0;
      held_off   = 1'b0;
      drained    = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty, one and two vertex tables, extreme square, unused code, small triangle.
      push_req(ppia_pkg::REQ_CLEAR, 16'sd0, 16'sd0);
      push_req(ppia_pkg::REQ_QUERY, 16'sd0, 16'sd0);
      push_req(ppia_pkg::REQ_APPEND, 16'sh8000, 16'sh8000);
      push_req(ppia_pkg::REQ_QUERY, 16'sh8000, 16'sh8000);
      push_req(ppia_pkg::REQ_APPEND, 16'sh7FFF, 16'sh8000);
      push_req(ppia_pkg::REQ_QUERY, 16'sd0, 16'sd0);
      push_req(ppia_pkg::REQ_APPEND, 16'sh7FFF, 16'sh7FFF);
      push_req(ppia_pkg::REQ_APPEND, 16'sh8000, 16'sh7FFF);
      push_req(ppia_pkg::REQ_QUERY, 16'sd0, 16'sd0);
      push_req(ppia_pkg::REQ_QUERY, 16'sh7FFF, 16'sd0);
      push_req(ppia_pkg::REQ_QUERY, 16'sh8000, 16'sd0);
      push_req(ppia_pkg::REQ_QUERY, 16'sh8000, 16'sh8000);
      push_req(ppia_pkg::REQ_QUERY, 16'sd0, 16'sh7FFF);
      push_req(REQ_UNUSED, 16'shFFFF, 16'shFFFF);
      push_req(ppia_pkg::REQ_CLEAR, 16'shFFFF, 16'shFFFF);
      push_req(ppia_pkg::REQ_APPEND, 16'sd0, 16'sd0);
      push_req(ppia_pkg::REQ_APPEND, 16'sd100, 16'sd0);
      push_req(ppia_pkg::REQ_APPEND, 16'sd0, 16'sd100);
      push_req(ppia_pkg::REQ_QUERY, 16'sd10, 16'sd0);
      push_req(ppia_pkg::REQ_QUERY, 16'sd10, 16'sd10);
      push_req(ppia_pkg::REQ_QUERY, 16'sd200, 16'sd50);
      push_req(ppia_pkg::REQ_QUERY, -16'sd5, 16'sd50);

      // Random: mostly clear, fill, query sequences; the rest is noise.
      while (items_sent < ITEM_TARGET) begin
         if (!held_off && items_sent >= 500) begin
            held_off = 1'b1;
            hold_go <= 1'b1;
         end
         if (!drained && items_sent >= 900) begin
            drained = 1'b1;
            wait_drained();
         end
         if (items_sent >= ITEM_TARGET - 200) idle_on <= 1'b0;
         if ($urandom_range(0, 9) < 8) begin
            wide_poly = ($urandom_range(0, 3) == 0);
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
            q = $urandom_range(1, 6);
            push_req(ppia_pkg::REQ_CLEAR, pick_coord(1), pick_coord(1));
            for (int i = 0; i < k; i++) begin
               push_req(ppia_pkg::REQ_APPEND, pick_coord(wide_poly), pick_coord(wide_poly));
               if ($urandom_range(0, 15) == 0)
                  push_req(REQ_UNUSED, pick_coord(1), pick_coord(1));
            end
            for (int i = 0; i < q; i++)
               push_req(ppia_pkg::REQ_QUERY,
                        pick_coord(wide_poly || $urandom_range(0, 7) == 0),
                        pick_coord(wide_poly || $urandom_range(0, 7) == 0));
         end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               push_req(ppia_pkg::REQ_TYPE_W'($urandom_range(0, 3)),
                        pick_coord(1), pick_coord(1));
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/ppia_pkg.sv
hw/rtl/ppia_ctrl.sv
hw/rtl/ppia_datapath.sv
hw/rtl/polygon_point_inside_and_area_unit.sv
tb/sv/polygon_answer_checker.sv
tb/sv/tb.sv
